FILE: src/rcs_pkg.sv
// rcs_pkg: types and constants shared by the rgb contrast stretch block
// no dependencies; used by rcs_ctrl, rcs_div, rcs_datapath and rgb_contrast_stretch

package rcs_pkg;

  localparam int PixW  = 8;
  localparam int NumW  = 2 * PixW;
  localparam logic [PixW-1:0] PixMax = 8'hff;
  localparam logic [PixW-1:0] PixMin = 8'h00;

  typedef struct packed {
    logic            command;
    logic            start_frame;
    logic [PixW-1:0] in_red;
    logic [PixW-1:0] in_green;
    logic [PixW-1:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] out_red;
    logic [PixW-1:0] out_green;
    logic [PixW-1:0] out_blue;
  } result_t;

  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_CONVERT = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // controller to datapath
  typedef struct packed {
    logic  take_pixel;
    logic  div_start;
    logic  store_chan;
    chan_t chan;
    logic  load_out;
  } rcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } rcs_stat_t;

endpackage

FILE: src/rcs_ctrl.sv
// rcs_ctrl: controller state machine of the contrast stretch block
// depends on rcs_pkg; drives rcs_datapath through rcs_cmd_t

module rcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  input  logic              pixel_command,
  output logic              pixel_ready,
  input  rcs_pkg::rcs_stat_t stat,
  output rcs_pkg::rcs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t         state, state_next;
  rcs_pkg::chan_t chan, chan_next;
  logic           take;

  assign pixel_ready = (state == S_IDLE);
  assign take        = pixel_ready && pixel_valid;

  always_comb begin
    state_next = state;
    chan_next  = chan;
    unique case (state)
      S_IDLE: begin
        if (take && (pixel_command == rcs_pkg::CMD_CONVERT)) begin
          state_next = S_LOAD;
          chan_next  = rcs_pkg::CH_RED;
        end
      end
      S_LOAD: state_next = S_RUN;
      S_RUN: begin
        if (stat.div_done) begin
          unique case (chan)
            rcs_pkg::CH_RED: begin
              chan_next  = rcs_pkg::CH_GREEN;
              state_next = S_LOAD;
            end
            rcs_pkg::CH_GREEN: begin
              chan_next  = rcs_pkg::CH_BLUE;
              state_next = S_LOAD;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= rcs_pkg::CH_RED;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  always_comb begin
    cmd.take_pixel = take;
    cmd.div_start  = (state == S_LOAD);
    cmd.store_chan = (state == S_RUN) && stat.div_done;
    cmd.chan       = chan;
    cmd.load_out   = (state == S_DONE) && stat.out_free;
  end

  a_convert_starts_red: assert property (@(posedge clk) disable iff (rst)
    take && (pixel_command == rcs_pkg::CMD_CONVERT) |=> state == S_LOAD && chan == rcs_pkg::CH_RED)
    else $error("convert transaction did not start on the red channel");

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == S_RUN)
    else $error("divider finished while controller was not waiting");

  a_blue_ends_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd.store_chan && chan == rcs_pkg::CH_BLUE |=> state == S_DONE)
    else $error("pixel not finished after blue channel");

endmodule

FILE: src/rcs_div.sv
// rcs_div: restoring divider, eight quotient bits, one bit per cycle
// depends on rcs_pkg; quotient must fit in eight bits (num < 256 * den)

module rcs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rcs_pkg::NumW-1:0]      num,
  input  logic [rcs_pkg::PixW-1:0]      den,
  output logic                          done,
  output logic [rcs_pkg::PixW-1:0]      quot
);

  localparam int CntW = $clog2(rcs_pkg::PixW);
  localparam logic [CntW-1:0] LastStep = CntW'(rcs_pkg::PixW - 1);

  logic                      busy;
  logic [CntW-1:0]           cnt;
  logic [rcs_pkg::PixW-1:0]  rem;
  logic [rcs_pkg::PixW-1:0]  lo;
  logic [rcs_pkg::PixW-1:0]  divisor;
  logic [rcs_pkg::PixW:0]    trial;
  logic                      fits;
  logic [rcs_pkg::PixW:0]    diff;

  assign trial = {rem, lo[rcs_pkg::PixW-1]};
  assign fits  = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};
  assign quot  = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // upper dividend half seeds the remainder, lower half shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num[rcs_pkg::NumW-1:rcs_pkg::PixW];
      lo      <= num[rcs_pkg::PixW-1:0];
      divisor <= den;
    end else if (busy) begin
      rem <= fits ? diff[rcs_pkg::PixW-1:0] : trial[rcs_pkg::PixW-1:0];
      lo  <= {lo[rcs_pkg::PixW-2:0], fits};
    end
  end

endmodule

FILE: src/rcs_datapath.sv
// rcs_datapath: min/max statistics, per-channel operand setup, shared divider
// and output register; depends on rcs_pkg and rcs_div

module rcs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rcs_pkg::pixel_t    pixel,
  input  rcs_pkg::rcs_cmd_t  cmd,
  output rcs_pkg::rcs_stat_t stat,
  output logic               result_valid,
  input  logic               result_ready,
  output rcs_pkg::result_t   result
);

  localparam int W = rcs_pkg::PixW;

  logic [W-1:0] low_red, high_red, low_green, high_green, low_blue, high_blue;
  logic [W-1:0] pix_red, pix_green, pix_blue;
  logic [W-1:0] res_red, res_green, res_blue;
  logic [W-1:0] sel_p, sel_lo, sel_hi;
  logic [W-1:0] delta, span;
  logic [rcs_pkg::NumW-1:0] num;
  logic [W-1:0] quot, stretched;
  logic         div_done;
  logic         measure;

  assign measure = cmd.take_pixel && (pixel.command == rcs_pkg::CMD_MEASURE);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_red    <= rcs_pkg::PixMax;
      low_green  <= rcs_pkg::PixMax;
      low_blue   <= rcs_pkg::PixMax;
      high_red   <= rcs_pkg::PixMin;
      high_green <= rcs_pkg::PixMin;
      high_blue  <= rcs_pkg::PixMin;
    end else if (measure) begin
      if (pixel.start_frame) begin
        low_red    <= pixel.in_red;
        high_red   <= pixel.in_red;
        low_green  <= pixel.in_green;
        high_green <= pixel.in_green;
        low_blue   <= pixel.in_blue;
        high_blue  <= pixel.in_blue;
      end else begin
        if (pixel.in_red   < low_red)    low_red    <= pixel.in_red;
        if (pixel.in_red   > high_red)   high_red   <= pixel.in_red;
        if (pixel.in_green < low_green)  low_green  <= pixel.in_green;
        if (pixel.in_green > high_green) high_green <= pixel.in_green;
        if (pixel.in_blue  < low_blue)   low_blue   <= pixel.in_blue;
        if (pixel.in_blue  > high_blue)  high_blue  <= pixel.in_blue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      pix_red   <= pixel.in_red;
      pix_green <= pixel.in_green;
      pix_blue  <= pixel.in_blue;
    end
  end

  always_comb begin
    unique case (cmd.chan)
      rcs_pkg::CH_RED: begin
        sel_p = pix_red;   sel_lo = low_red;   sel_hi = high_red;
      end
      rcs_pkg::CH_GREEN: begin
        sel_p = pix_green; sel_lo = low_green; sel_hi = high_green;
      end
      rcs_pkg::CH_BLUE: begin
        sel_p = pix_blue;  sel_lo = low_blue;  sel_hi = high_blue;
      end
      default: begin
        sel_p = pix_red;   sel_lo = low_red;   sel_hi = high_red;
      end
    endcase
  end

  // 255 * (p - min) as (x << 8) - x
  assign delta = sel_p - sel_lo;
  assign span  = sel_hi - sel_lo;
  assign num   = {delta, {W{1'b0}}} - {{W{1'b0}}, delta};

  rcs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (num),
    .den  (span),
    .done (div_done),
    .quot (quot)
  );

  // empty or flat range and pixel at or below min give 0, at or above max 255
  always_comb begin
    if (sel_hi <= sel_lo || sel_p <= sel_lo) begin
      stretched = rcs_pkg::PixMin;
    end else if (sel_p >= sel_hi) begin
      stretched = rcs_pkg::PixMax;
    end else begin
      stretched = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_chan) begin
      case (cmd.chan)
        rcs_pkg::CH_RED:   res_red   <= stretched;
        rcs_pkg::CH_GREEN: res_green <= stretched;
        default:           res_blue  <= stretched;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.out_red   <= res_red;
      result.out_green <= res_green;
      result.out_blue  <= res_blue;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_free = !result_valid || result_ready;

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("loaded result not presented");

  a_stats_ordered: assert property (@(posedge clk) disable iff (rst)
    measure |=> low_red <= high_red && low_green <= high_green && low_blue <= high_blue)
    else $error("min above max after a measure transaction");

  a_store_after_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !div_done)
    else $error("divider reported done right after start");

endmodule

FILE: src/rgb_contrast_stretch.sv
// Per-channel min/max contrast stretch. A measure transaction (command 0) folds
// the pixel into running min/max per channel when it is accepted, restarting
// them when start_frame is set, and gives no result. A convert transaction
// (command 1) maps each channel to floor(255*(p-min)/(max-min)), 0 for a flat
// or empty range or a pixel at or below min, 255 at or above max. One shared
// restoring divider produces eight quotient bits per channel, one per cycle,
// with a setup step before and a store step after each channel, and
// pixel_ready is high only while the block is idle. Measures are accepted
// while a finished result still waits.
// depends on rcs_pkg, rcs_ctrl, rcs_datapath

module rgb_contrast_stretch (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  rcs_pkg::pixel_t  pixel,
  output logic             result_valid,
  input  logic             result_ready,
  output rcs_pkg::result_t result
);

  rcs_pkg::rcs_cmd_t  cmd;
  rcs_pkg::rcs_stat_t stat;

  rcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_command(pixel.command),
    .pixel_ready  (pixel_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rcs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule
